@@ rtl/next_fit_slot_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_macros
// Assertion macros shared by the slot allocator checkers.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_SLOT_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define NFSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define NFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared sizes, codes and types of the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  // Table size and field widths
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CMD_W   = 2;
  localparam int REQ_W   = 8;
  localparam int OPT_W   = 8;
  localparam int LIM_W   = 6;
  localparam int STS_W   = 3;
  localparam int RES_W   = 6;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd3;

  // Result status codes
  localparam logic [STS_W-1:0] STS_OK           = 3'd0;
  localparam logic [STS_W-1:0] STS_IN_USE       = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL         = 3'd2;
  localparam logic [STS_W-1:0] STS_INVALID      = 3'd3;
  localparam logic [STS_W-1:0] STS_QUEUE_NEEDED = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MAX_INDEX    = 2'd0;
  localparam logic [1:0] REG_ALLOWED_OPTS = 2'd1;
  localparam logic [1:0] REG_FLOW_CTRL    = 2'd2;

  // Register reset values
  localparam logic [LIM_W-1:0] MAX_INDEX_RST    = 6'd63;
  localparam logic [OPT_W-1:0] ALLOWED_OPTS_RST = 8'hFF;
  localparam logic [OPT_W-1:0] FLOW_CTRL_RST    = 8'h01;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } dp_cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [LIM_W-1:0] max_index;
    logic [OPT_W-1:0] allowed_options;
    logic [OPT_W-1:0] flow_control_option;
  } cfg_t;

endpackage

@@ rtl/nfsa_regs.sv @@
// ----------------------------------------------------------------------------
// nfsa_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module nfsa_regs
  import nfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_MAX_INDEX:    cfg_nxt.max_index           = pwdata[LIM_W-1:0];
        REG_ALLOWED_OPTS: cfg_nxt.allowed_options     = pwdata[OPT_W-1:0];
        REG_FLOW_CTRL:    cfg_nxt.flow_control_option = pwdata[OPT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_index           <= MAX_INDEX_RST;
      cfg_r.allowed_options     <= ALLOWED_OPTS_RST;
      cfg_r.flow_control_option <= FLOW_CTRL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_MAX_INDEX:    prdata = DATA_W'(cfg_r.max_index);
      REG_ALLOWED_OPTS: prdata = DATA_W'(cfg_r.allowed_options);
      REG_FLOW_CTRL:    prdata = DATA_W'(cfg_r.flow_control_option);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/nfsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Request sequencer: accept, evaluate, commit, and the result valid flag.
// ----------------------------------------------------------------------------
module nfsa_ctrl
  import nfsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CHECK  = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_commit;

  assign in_ready   = (state_r == S_IDLE);
  assign can_commit = !out_valid_r || out_ready;

  // Advance the sequence of one request
  always_comb begin
    state_nxt     = state_r;
    dp_cmd        = '0;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        dp_cmd.eval = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register is free
        if (can_commit) begin
          dp_cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/nfsa_datapath.sv @@
// ----------------------------------------------------------------------------
// nfsa_datapath
// Slot table, next-fit search, request checks and result register.
// ----------------------------------------------------------------------------
module nfsa_datapath
  import nfsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          dp_cmd,
  input  cfg_t             cfg,
  input  logic [CMD_W-1:0] command,
  input  logic             any_index,
  input  logic [REQ_W-1:0] index,
  input  logic [OPT_W-1:0] options,
  input  logic             queue_present,
  input  logic             lists_empty,
  output logic [STS_W-1:0] status,
  output logic [RES_W-1:0] result_index
);

  // Request register
  logic [CMD_W-1:0] cmd_r;
  logic             any_r;
  logic [REQ_W-1:0] idx_r;
  logic [OPT_W-1:0] opt_r;
  logic             queue_r;
  logic             empty_r;

  // Slot table
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [ENTRIES-1:0] enabled_r, enabled_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;

  // Evaluation stage
  logic [STS_W-1:0] eval_sts_r, eval_sts;
  logic [IDX_W-1:0] eval_slot_r, eval_slot;

  // Result register
  logic [STS_W-1:0] out_sts_r;
  logic [RES_W-1:0] out_idx_r;

  logic [IDX_W-1:0]   lim;
  logic [ENTRIES-1:0] free_v, above_v;
  logic               hi_found, lo_found;
  logic [IDX_W-1:0]   hi_idx, lo_idx;
  logic [IDX_W-1:0]   tgt;
  logic               req_over;

  // Capture the request
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= command;
      any_r   <= any_index;
      idx_r   <= index;
      opt_r   <= options;
      queue_r <= queue_present;
      empty_r <= lists_empty;
    end
  end

  // Clamp the usable top index to the table size
  always_comb begin
    if (int'(cfg.max_index) > ENTRIES - 1) begin
      lim = IDX_W'(ENTRIES - 1);
    end else begin
      lim = IDX_W'(cfg.max_index);
    end
  end

  assign req_over = int'(idx_r) > int'(lim);
  assign tgt      = idx_r[IDX_W-1:0];

  // Free slots within the limit, and those past the last grant
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      free_v[i]  = !used_r[i] && (i <= int'(lim));
      above_v[i] = i > int'(last_r);
    end
  end

  // Lowest free slot past the last grant, and lowest free slot overall
  always_comb begin
    hi_found = 1'b0;
    hi_idx   = '0;
    lo_found = 1'b0;
    lo_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_v[i] && above_v[i]) begin
        hi_found = 1'b1;
        hi_idx   = IDX_W'(i);
      end
      if (free_v[i]) begin
        lo_found = 1'b1;
        lo_idx   = IDX_W'(i);
      end
    end
  end

  // Check the request and pick the slot
  always_comb begin
    eval_sts  = STS_OK;
    eval_slot = tgt;
    if (cmd_r == CMD_ALLOC) begin
      if ((opt_r & ~cfg.allowed_options) != '0) begin
        eval_sts = STS_INVALID;
      end else if ((opt_r & cfg.flow_control_option) != '0 && !queue_r) begin
        eval_sts = STS_QUEUE_NEEDED;
      end else if (!any_r) begin
        if (req_over) begin
          eval_sts = STS_INVALID;
        end else if (used_r[tgt]) begin
          eval_sts = STS_IN_USE;
        end
      end else if (hi_found) begin
        eval_slot = hi_idx;
      end else if (lo_found) begin
        eval_slot = lo_idx;
      end else begin
        eval_sts = STS_FULL;
      end
    end else if (req_over || !used_r[tgt]) begin
      eval_sts = STS_INVALID;
    end else if (cmd_r == CMD_FREE && !empty_r) begin
      eval_sts = STS_IN_USE;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.eval) begin
      eval_sts_r  <= eval_sts;
      eval_slot_r <= eval_slot;
    end
  end

  // Apply a successful command to the table
  always_comb begin
    used_nxt    = used_r;
    enabled_nxt = enabled_r;
    last_nxt    = last_r;
    if (dp_cmd.commit && eval_sts_r == STS_OK) begin
      case (cmd_r)
        CMD_ALLOC: begin
          used_nxt[eval_slot_r]    = 1'b1;
          enabled_nxt[eval_slot_r] = 1'b1;
          last_nxt                 = eval_slot_r;
        end
        CMD_FREE: begin
          used_nxt[eval_slot_r]    = 1'b0;
          enabled_nxt[eval_slot_r] = 1'b0;
        end
        CMD_DISABLE: enabled_nxt[eval_slot_r] = 1'b0;
        CMD_ENABLE:  enabled_nxt[eval_slot_r] = 1'b1;
        default:     last_nxt = last_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      enabled_r <= '0;
      last_r    <= IDX_W'(ENTRIES - 1);
    end else begin
      used_r    <= used_nxt;
      enabled_r <= enabled_nxt;
      last_r    <= last_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      out_sts_r <= eval_sts_r;
      if (cmd_r == CMD_ALLOC && eval_sts_r == STS_OK) begin
        out_idx_r <= RES_W'(eval_slot_r);
      end else begin
        out_idx_r <= '0;
      end
    end
  end

  assign status       = out_sts_r;
  assign result_index = out_idx_r;

endmodule

@@ rtl/next_fit_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Slot table with allocate, free, disable and enable requests.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. A request is captured first; then
// come the checks and the next-fit search (a priority pick over the 64 slot
// marks, registered); then the table is updated and the result register
// loaded. A new request is taken only after the previous one has committed;
// a result left waiting on the output holds the commit step. The table needs
// no clearing pass: all slot marks clear at reset.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator
  import nfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // any_index[0], index[8:1], options[16:9],
                                        // queue_present[17], lists_empty[18], zero pad
  input  logic [CMD_W-1:0]  in_tuser,   // command[1:0]
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // status[2:0], result_index[8:3], zero pad
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  dp_cmd_t          dp_cmd;
  cfg_t             cfg;
  logic [STS_W-1:0] status;
  logic [RES_W-1:0] result_index;

  nfsa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  nfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dp_cmd    (dp_cmd)
  );

  nfsa_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_cmd        (dp_cmd),
    .cfg           (cfg),
    .command       (in_tuser),
    .any_index     (in_tdata[0]),
    .index         (in_tdata[8:1]),
    .options       (in_tdata[16:9]),
    .queue_present (in_tdata[17]),
    .lists_empty   (in_tdata[18]),
    .status        (status),
    .result_index  (result_index)
  );

  // Pack the result
  assign out_tdata = {{(OUT_W - STS_W - RES_W){1'b0}}, result_index, status};

endmodule

@@ rtl/nfsa_checker.sv @@
// ----------------------------------------------------------------------------
// nfsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "next_fit_slot_allocator_macros.svh"

module nfsa_checker
  import nfsa_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result holds
  `NFSA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  // Only a grant carries a slot index
  `NFSA_ASSERT_SAME(a_idx_zero, out_tvalid && out_tdata[2:0] != STS_OK, out_tdata[8:3] == '0, "index on failed request")
  // Status is one of the defined codes
  `NFSA_ASSERT_SAME(a_sts_range, out_tvalid, out_tdata[2:0] <= STS_QUEUE_NEEDED, "undefined status")
  // One request in flight at a time
  `NFSA_ASSERT_NEXT(a_one_req, in_tvalid && in_tready, !in_tready, "request taken while busy")

endmodule

bind next_fit_slot_allocator nfsa_checker u_nfsa_checker (.*);
